// ----- src/stg_pkg.sv -----
// Shared types, constants and the quarter-wave sine table for the swept tone generator.
// Depends on nothing; every other file of the block imports it.
package stg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int LIMIT_W    = 32;
    localparam int FACTOR_W   = 17;
    localparam int AMP_W      = 15;
    localparam int ENTRY_W    = 15;
    localparam int LFSR_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam int PROD_W      = PHASE_BITS + FACTOR_W;
    localparam int FRAC_SHIFT  = 16;
    localparam int TONE_SHIFT  = 15;
    localparam int NOISE_SHIFT = 16;
    localparam int NOISE_W     = 15;
    localparam int CMP_W       = (PHASE_BITS > LIMIT_W) ? PHASE_BITS : LIMIT_W;
    localparam int SUM_W       = (SAMPLE_BITS + 1 > 17) ? SAMPLE_BITS + 1 : 17;

    localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
    localparam int QIDX_W  = TABLE_ADDR_BITS - 1;

    localparam logic [LIMIT_W-1:0]  START_INC_RESET  = 32'd584349291;
    localparam logic [LIMIT_W-1:0]  LOW_LIMIT_RESET  = 32'd9739155;
    localparam logic [LIMIT_W-1:0]  HIGH_LIMIT_RESET = 32'd584349291;
    localparam logic [FACTOR_W-1:0] DOWN_FACTOR_RESET = 17'd58982;
    localparam logic [FACTOR_W-1:0] UP_FACTOR_RESET   = 17'd72818;
    localparam logic [AMP_W-1:0]    TONE_AMP_RESET    = 15'd27767;
    localparam logic [AMP_W-1:0]    NOISE_AMP_RESET   = 15'd5000;
    localparam logic [LFSR_W-1:0]   LFSR_SEED         = 16'd44257;
    localparam logic [LFSR_W-1:0]   LFSR_TAPS         = 16'hB400;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_INC  = 3'd0,
        REG_LOW_LIMIT  = 3'd1,
        REG_HIGH_LIMIT = 3'd2,
        REG_DOWN_FACT  = 3'd3,
        REG_UP_FACT    = 3'd4,
        REG_TONE_AMP   = 3'd5,
        REG_NOISE_AMP  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]  low_limit;
        logic [LIMIT_W-1:0]  high_limit;
        logic [FACTOR_W-1:0] down_factor;
        logic [FACTOR_W-1:0] up_factor;
        logic [AMP_W-1:0]    tone_amp;
        logic [AMP_W-1:0]    noise_amp;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP_MUL,
        ST_SWEEP_UPD,
        ST_ADVANCE,
        ST_TONE,
        ST_NOISE,
        ST_FINISH
    } stg_state_t;

    typedef struct packed {
        logic sweep_mul;
        logic sweep_upd;
        logic advance;
        logic tone_mul;
        logic noise_mul;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    // Q30 constants of the sine series, used only while the table is built.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [7:1][7:0] SERIES_DIV = {8'd210, 8'd156, 8'd110, 8'd72,
                                              8'd42, 8'd20, 8'd6};

    typedef logic [QUARTER:0][ENTRY_W-1:0] qtab_t;

    function automatic logic [ENTRY_W-1:0] sine_q15(input int unsigned i);
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] y;
        x = (64'(i) * HALF_PI_Q30) / QUARTER;
        s = (x * x) >> 30;
        t = ONE_Q30;
        for (int k = 7; k >= 1; k--) begin
            d = ((s * t) >> 30) / 64'(SERIES_DIV[k]);
            t = ONE_Q30 - d;
        end
        y = ((((x * t) >> 30) * 64'd32767) + (ONE_Q30 >> 1)) >> 30;
        return y[ENTRY_W-1:0];
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t tab;
        for (int i = 0; i <= QUARTER; i++) begin
            tab[i] = sine_q15(i);
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    // Returns {negative, magnitude} of the full-cycle sine entry at idx.
    function automatic logic [ENTRY_W:0] sine_entry(input logic [TABLE_ADDR_BITS-1:0] idx);
        logic [1:0]        q;
        logic [QIDX_W-1:0] r;
        logic [QIDX_W-1:0] ridx;
        q    = idx[TABLE_ADDR_BITS-1 -: 2];
        r    = {1'b0, idx[TABLE_ADDR_BITS-3:0]};
        ridx = q[0] ? (QIDX_W'(QUARTER) - r) : r;
        return {q[1], QTAB[ridx]};
    endfunction

endpackage

// ----- src/stg_cfg_regs.sv -----
// Configuration register file of the swept tone generator.
// Depends on stg_pkg; a write of the start increment also signals a load of the increment.
module stg_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [stg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output stg_pkg::cfg_t                   cfg,
    output logic                            inc_load,
    output logic [stg_pkg::PHASE_BITS-1:0]  inc_load_value
);
    import stg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        inc_load = 1'b0;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_START_INC:  inc_load = 1'b1;
                REG_LOW_LIMIT:  cfg_next.low_limit   = cfg_wdata[LIMIT_W-1:0];
                REG_HIGH_LIMIT: cfg_next.high_limit  = cfg_wdata[LIMIT_W-1:0];
                REG_DOWN_FACT:  cfg_next.down_factor = cfg_wdata[FACTOR_W-1:0];
                REG_UP_FACT:    cfg_next.up_factor   = cfg_wdata[FACTOR_W-1:0];
                REG_TONE_AMP:   cfg_next.tone_amp    = cfg_wdata[AMP_W-1:0];
                REG_NOISE_AMP:  cfg_next.noise_amp   = cfg_wdata[AMP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_limit   <= LOW_LIMIT_RESET;
            cfg_reg.high_limit  <= HIGH_LIMIT_RESET;
            cfg_reg.down_factor <= DOWN_FACTOR_RESET;
            cfg_reg.up_factor   <= UP_FACTOR_RESET;
            cfg_reg.tone_amp    <= TONE_AMP_RESET;
            cfg_reg.noise_amp   <= NOISE_AMP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg            = cfg_reg;
    assign inc_load_value = PHASE_BITS'(cfg_wdata);

endmodule

// ----- src/stg_datapath.sv -----
// Datapath of the swept tone generator: phase accumulator, sweep, sine table, LFSR,
// one shared multiplier and the output register. Depends on stg_pkg.
module stg_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  stg_pkg::ctrl_cmd_t              cmd,
    input  stg_pkg::cfg_t                   cfg,
    input  logic                            inc_load,
    input  logic [stg_pkg::PHASE_BITS-1:0]  inc_load_value,
    output stg_pkg::dp_status_t             status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stg_pkg::M_TDATA_W-1:0]   m_tdata
);
    import stg_pkg::*;

    logic [PHASE_BITS-1:0]   phase_reg, phase_next;
    logic [PHASE_BITS-1:0]   inc_reg, inc_next;
    logic                    down_reg, down_next;
    logic [LFSR_W-1:0]       lfsr_reg, lfsr_next;
    logic [PROD_W-1:0]       mul_reg, mul_next;
    logic                    neg_reg, neg_next;
    logic [ENTRY_W-1:0]      mag_reg, mag_next;
    logic signed [SUM_W-1:0] tone_reg, tone_next;
    logic                    valid_reg, valid_next;
    logic [SAMPLE_BITS-1:0]  data_reg, data_next;

    logic [PHASE_BITS-1:0]   mul_a;
    logic [FACTOR_W-1:0]     mul_b;
    logic [PHASE_BITS:0]     prod_shift;
    logic [PHASE_BITS-1:0]   inc_sat;
    logic [PHASE_BITS-1:0]   phase_sum;
    logic [ENTRY_W:0]        entry;
    logic [SUM_W-1:0]        tone_ext;
    logic signed [SUM_W-1:0] sum;

    // One multiplier serves the sweep step, the tone scaling and the noise scaling.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sweep_mul) begin
            mul_a = inc_reg;
            mul_b = down_reg ? cfg.down_factor : cfg.up_factor;
        end else if (cmd.tone_mul) begin
            mul_a = PHASE_BITS'(mag_reg);
            mul_b = FACTOR_W'(cfg.tone_amp);
        end else if (cmd.noise_mul) begin
            mul_a = PHASE_BITS'(lfsr_reg);
            mul_b = FACTOR_W'(cfg.noise_amp);
        end
    end

    assign prod_shift = mul_reg[PROD_W-1:FRAC_SHIFT];
    assign inc_sat    = prod_shift[PHASE_BITS] ? '1 : prod_shift[PHASE_BITS-1:0];
    assign phase_sum  = phase_reg + inc_reg;
    assign entry      = sine_entry(phase_sum[PHASE_BITS-1 -: TABLE_ADDR_BITS]);
    assign tone_ext   = SUM_W'(mul_reg[TONE_SHIFT +: ENTRY_W]);
    assign sum        = tone_reg + $signed(SUM_W'(mul_reg[NOISE_SHIFT +: NOISE_W]));

    always_comb begin
        phase_next = phase_reg;
        inc_next   = inc_reg;
        down_next  = down_reg;
        lfsr_next  = lfsr_reg;
        mul_next   = mul_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        tone_next  = tone_reg;
        valid_next = valid_reg;
        data_next  = data_reg;

        if (inc_load) begin
            inc_next = inc_load_value;
        end

        if (cmd.sweep_mul || cmd.tone_mul || cmd.noise_mul) begin
            mul_next = PROD_W'(mul_a) * PROD_W'(mul_b);
        end

        if (cmd.sweep_upd) begin
            inc_next = inc_sat;
            // The low limit is checked first, so it wins when both are crossed.
            if (CMP_W'(inc_sat) < CMP_W'(cfg.low_limit)) begin
                down_next = 1'b0;
            end else if (CMP_W'(inc_sat) > CMP_W'(cfg.high_limit)) begin
                down_next = 1'b1;
            end
        end

        if (cmd.advance) begin
            phase_next = phase_sum;
            neg_next   = entry[ENTRY_W];
            mag_next   = entry[ENTRY_W-1:0];
            lfsr_next  = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
        end

        if (cmd.noise_mul) begin
            tone_next = neg_reg ? -$signed(tone_ext) : $signed(tone_ext);
        end

        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end

        if (cmd.finish) begin
            valid_next = 1'b1;
            if (sum > SAT_MAX) begin
                data_next = SAT_MAX[SAMPLE_BITS-1:0];
            end else if (sum < SAT_MIN) begin
                data_next = SAT_MIN[SAMPLE_BITS-1:0];
            end else begin
                data_next = sum[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            inc_reg   <= PHASE_BITS'(START_INC_RESET);
            down_reg  <= 1'b1;
            lfsr_reg  <= LFSR_SEED;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            inc_reg   <= inc_next;
            down_reg  <= down_next;
            lfsr_reg  <= lfsr_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg  <= mul_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        tone_reg <= tone_next;
        data_reg <= data_next;
    end

    assign status.out_busy = valid_reg && !m_tready;
    assign m_tvalid        = valid_reg;
    assign m_tdata         = M_TDATA_W'(data_reg);

endmodule

// ----- src/stg_ctrl.sv -----
// Controller of the swept tone generator: sequences the datapath through one sample.
// Depends on stg_pkg for the state type and the command and status structs.
module stg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 in_buffer_start,
    input  stg_pkg::dp_status_t  status,
    output stg_pkg::ctrl_cmd_t   cmd
);
    import stg_pkg::*;

    stg_state_t state_reg;
    stg_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = in_buffer_start ? ST_SWEEP_MUL : ST_ADVANCE;
                end
            end
            ST_SWEEP_MUL: begin
                cmd.sweep_mul = 1'b1;
                state_next    = ST_SWEEP_UPD;
            end
            ST_SWEEP_UPD: begin
                cmd.sweep_upd = 1'b1;
                state_next    = ST_ADVANCE;
            end
            ST_ADVANCE: begin
                cmd.advance = 1'b1;
                state_next  = ST_TONE;
            end
            ST_TONE: begin
                cmd.tone_mul = 1'b1;
                state_next   = ST_NOISE;
            end
            ST_NOISE: begin
                cmd.noise_mul = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                // Hold the finished sum until the previous result has left.
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/swept_tone_generator_with_noise_core.sv -----
// Swept tone generator with noise, top level: config registers, controller and datapath.
// Depends on stg_pkg, stg_cfg_regs, stg_ctrl and stg_datapath.
//
// Each input transaction requests one signed audio sample; bit 0 of s_tdata marks the first
// sample of a buffer, which first multiplies the phase increment by the active sweep factor
// and may turn the sweep direction. After accepting a request the controller steps through
// its advance, tone, noise and finish states and takes no new request until it is idle again;
// a buffer start adds the sweep multiply and sweep update states first, because a single
// shared multiplier handles the sweep step, the tone scaling and the noise scaling in turn.
// The result sits in an output register, so the next request is accepted while it waits;
// the next result is held back only while that register is still occupied. Configuration
// is written through cfg_we, cfg_index and cfg_wdata; the user must write it only while no
// sample is in flight, as the block itself does not enforce this. Writing the start increment
// also reloads the running increment.
module swept_tone_generator_with_noise_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stg_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] buffer_start, rest zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stg_pkg::M_TDATA_W-1:0]   m_tdata,   // [15:0] sample
    input  logic                            cfg_we,
    input  logic [stg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import stg_pkg::*;

    cfg_t                  cfg;
    logic                  inc_load;
    logic [PHASE_BITS-1:0] inc_load_value;
    ctrl_cmd_t             cmd;
    dp_status_t            status;

    stg_cfg_regs u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .cfg            (cfg),
        .inc_load       (inc_load),
        .inc_load_value (inc_load_value)
    );

    stg_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .in_buffer_start (s_tdata[0]),
        .status          (status),
        .cmd             (cmd)
    );

    stg_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg            (cfg),
        .inc_load       (inc_load),
        .inc_load_value (inc_load_value),
        .status         (status),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule
